// ===== src/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// lss_pkg
// Types and codes shared by the LIFO stack with search.
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int VAL_W  = 32;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;
    localparam int POS_W  = 5;

    // Request operations
    localparam logic [FUNC_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [FUNC_W-1:0] OP_POP    = 2'd1;
    localparam logic [FUNC_W-1:0] OP_SEARCH = 2'd2;

    // Response status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic signed [VAL_W-1:0] value;
    } req_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] result_value;
        logic [POS_W-1:0]        position;
    } rsp_item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEARCH,
        S_DONE
    } state_t;

endpackage

// ===== src/lss_ram.sv =====
// ----------------------------------------------------------------------------
// lss_ram
// Stack entry storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lss_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [AW-1:0]                   wr_addr,
    input  logic signed [lss_pkg::VAL_W-1:0] wr_data,
    input  logic                            rd_en,
    input  logic [AW-1:0]                   rd_addr,
    output logic signed [lss_pkg::VAL_W-1:0] rd_data
);
    import lss_pkg::*;

    logic signed [VAL_W-1:0] mem [DEPTH];
    logic signed [VAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/lifo_stack_with_search_top.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_with_search_top
// Bounded LIFO stack of signed 32-bit values with push, pop and top-down search.
//
// One request is taken at a time. A push, a no-op, or any request answered
// from the fill count alone (full, empty) goes straight to the completion
// state; a pop passes through one extra state for the registered memory read.
// A search compares entries from the top down until a match, or on a miss
// until all filled entries (at most DEPTH) have been compared: the walk
// reads one entry per cycle through the single memory read port and compares
// it against the key in one shared comparator. A new request is accepted while
// a finished response still waits in the output register.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_top #(
    parameter int DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  lss_pkg::req_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output lss_pkg::rsp_item_t  rsp
);
    import lss_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    state_t state_reg, state_next;

    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           pos_reg, pos_next;
    logic [AW-1:0]           addr_reg, addr_next;
    logic signed [VAL_W-1:0] key_reg, key_next;
    rsp_item_t               res_reg, res_next;
    rsp_item_t               rsp_reg, rsp_next;
    logic                    rsp_valid_reg, rsp_valid_next;

    logic                    accept;
    logic                    full;
    logic                    empty;
    logic                    out_free;
    logic                    hit;
    logic                    last;
    logic [CW-1:0]           top_idx;
    logic [CW-1:0]           below_top_idx;
    logic [CW+POS_W-1:0]     pos_ext;

    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic signed [VAL_W-1:0] rd_data;

    lss_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req_ready     = (state_reg == S_IDLE);
    assign accept        = req_valid && req_ready;
    assign full          = (count_reg == CW'(DEPTH));
    assign empty         = (count_reg == '0);
    assign out_free      = !rsp_valid_reg || rsp_ready;
    assign top_idx       = count_reg - CW'(1);
    assign below_top_idx = count_reg - CW'(2);
    assign hit           = (rd_data == key_reg);
    assign last          = (pos_reg == count_reg);
    // position field is the 1-based match index truncated to its field width
    assign pos_ext       = {{POS_W{1'b0}}, pos_reg};

    // ---- next state ----
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.func == OP_POP && !empty)
                        state_next = S_READ;
                    else if (req.func == OP_SEARCH && !empty)
                        state_next = S_SEARCH;
                    else
                        state_next = S_DONE;
                end
            end
            S_READ:
                state_next = S_DONE;
            S_SEARCH:
            begin
                if (hit || last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // ---- datapath and outputs ----
    always_comb
    begin
        count_next     = count_reg;
        pos_next       = pos_reg;
        addr_next      = addr_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        wr_en          = 1'b0;
        wr_addr        = count_reg[AW-1:0];
        rd_en          = 1'b0;
        rd_addr        = top_idx[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next = '{status: ST_OK, result_value: '0, position: '0};
                    key_next = req.value;
                    case (req.func)
                        OP_PUSH:
                        begin
                            if (full)
                                res_next.status = ST_FULL;
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (empty)
                                res_next.status = ST_EMPTY;
                            else
                            begin
                                rd_en      = 1'b1;
                                count_next = top_idx;
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (empty)
                                res_next.status = ST_EMPTY;
                            else
                            begin
                                rd_en     = 1'b1;
                                pos_next  = CW'(1);
                                addr_next = below_top_idx[AW-1:0];
                            end
                        end
                        default:
                        begin
                            // unused selector: no operation, ok status
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_next.result_value = rd_data;
            end
            S_SEARCH:
            begin
                if (hit)
                begin
                    res_next.result_value = key_reg;
                    res_next.position     = pos_ext[POS_W-1:0];
                end
                else if (last)
                    res_next.status = ST_MISS;
                else
                begin
                    // fetch the next entry down while this one was compared
                    rd_en     = 1'b1;
                    rd_addr   = addr_reg;
                    addr_next = addr_reg - AW'(1);
                    pos_next  = pos_reg + CW'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        addr_reg <= addr_next;
        key_reg  <= key_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---- assertions ----
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count exceeds depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.func == OP_PUSH && !full) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("push did not grow the stack");

    a_search_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (pos_reg != '0 && pos_reg <= count_reg))
        else $error("search position out of range");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg) == S_DONE)
        else $error("response raised outside completion");

endmodule

// ===== sim/lifo_stack_with_search_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_stack_with_search_top_tb
// Self-checking bench for the LIFO stack with search. A mirror of the stack
// predicts each response as requests are accepted; responses are checked in
// order. Directed corner items come first, then biased random traffic with
// random stalls on both channels, a long response hold-off and a drain pause.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_top_tb;

    import lss_pkg::*;

    class stack_mirror #(int DEPTH = 16);

        rsp_item_t               pending_rsp[$];
        logic signed [VAL_W-1:0] entry_mem[DEPTH];
        int unsigned             entry_cnt;
        int unsigned             mismatch_cnt;

        function new();
            entry_cnt    = 0;
            mismatch_cnt = 0;
        endfunction

        // Accepted request: update the mirror and queue the response it implies
        function void note_request(req_item_t r);
            rsp_item_t e;
            bit        found;
            e     = '0;
            found = 1'b0;
            case (r.func)
                OP_PUSH:
                begin
                    if (entry_cnt >= DEPTH)
                        e.status = ST_FULL;
                    else
                    begin
                        entry_mem[entry_cnt] = r.value;
                        entry_cnt++;
                        e.status = ST_OK;
                    end
                end
                OP_POP:
                begin
                    if (entry_cnt == 0)
                        e.status = ST_EMPTY;
                    else
                    begin
                        entry_cnt--;
                        e.status       = ST_OK;
                        e.result_value = entry_mem[entry_cnt];
                    end
                end
                OP_SEARCH:
                begin
                    if (entry_cnt == 0)
                        e.status = ST_EMPTY;
                    else
                    begin
                        e.status = ST_MISS;
                        // walk from the top down, first hit wins
                        for (int i = 0; i < entry_cnt; i++)
                        begin
                            if (!found && entry_mem[entry_cnt - 1 - i] == r.value)
                            begin
                                found          = 1'b1;
                                e.status       = ST_OK;
                                e.result_value = r.value;
                                e.position     = POS_W'(i + 1);
                            end
                        end
                    end
                end
                default:
                    e = '0;
            endcase
            pending_rsp.push_back(e);
        endfunction

        function void check_response(rsp_item_t a);
            rsp_item_t e;
            if (pending_rsp.size() == 0)
            begin
                if (mismatch_cnt < 10)
                    $display("unexpected item: status %0d value %0d pos %0d",
                             a.status, a.result_value, a.position);
                mismatch_cnt++;
            end
            else
            begin
                e = pending_rsp.pop_front();
                if (a.status !== e.status || a.result_value !== e.result_value ||
                    a.position !== e.position)
                begin
                    if (mismatch_cnt < 10)
                        $display(
                            "mismatch: exp st %0d val %0d pos %0d / got st %0d val %0d pos %0d",
                            e.status, e.result_value, e.position,
                            a.status, a.result_value, a.position);
                    mismatch_cnt++;
                end
            end
        endfunction

    endclass

    localparam int DEPTH     = 16;
    localparam int LIMIT     = 1000000;
    localparam int HOLD_CYC  = 400;

    localparam logic [FUNC_W-1:0] OP_NONE = 2'd3;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_item_t req       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp;

    bit        idle_on       = 1'b0;
    bit        long_hold_req = 1'b0;
    mix_t      mix_mode      = MIX_EVEN;
    int        mode_left     = 0;
    int        cycle_count   = 0;

    stack_mirror #(DEPTH) sb;

    lifo_stack_with_search_top #(
        .DEPTH (DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_request(req);
            if (rsp_valid && rsp_ready)
                sb.check_response(rsp);
        end
    end

    // Response side: random stall bursts plus one long hold-off on request
    initial
    begin : rsp_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                hold_left     = HOLD_CYC;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    task automatic offer_req(input logic [FUNC_W-1:0] f,
                             input logic signed [VAL_W-1:0] v);
        req_item_t item;
        item.func  = f;
        item.value = v;
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic sender_gap(input bit allow);
        if (allow && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic wait_all_answered();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [VAL_W-1:0] corner_value();
        case ($urandom_range(0, 6))
            0:       return 32'sh0000_0000;
            1:       return 32'sh0000_0001;
            2:       return 32'shFFFF_FFFF;
            3:       return 32'sh8000_0000;
            4:       return 32'sh7FFF_FFFF;
            5:       return 32'sh5555_5555;
            default: return 32'shAAAA_AAAA;
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] stored_value();
        if (sb.entry_cnt == 0)
            return $urandom;
        return sb.entry_mem[$urandom_range(0, sb.entry_cnt - 1)];
    endfunction

    // Mix of fresh random values, corners and duplicates of stored entries
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0, 1:    return $urandom;
            2:       return corner_value();
            default: return stored_value();
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_key();
        if ($urandom_range(0, 4) < 3)
            return stored_value();
        return pick_value();
    endfunction

    task automatic run_random(input int count, input bit gaps);
        int                      pick;
        int                      push_lim;
        int                      pop_lim;
        logic [FUNC_W-1:0]       f;
        logic signed [VAL_W-1:0] v;
        for (int k = 0; k < count; k++)
        begin
            // bias in runs so the stack regularly hits both full and empty
            if (mode_left == 0)
            begin
                mix_mode  = mix_t'($urandom_range(0, 2));
                mode_left = $urandom_range(10, 50);
            end
            mode_left--;
            case (mix_mode)
                MIX_FILL:
                begin
                    push_lim = 65;
                    pop_lim  = 80;
                end
                MIX_DRAIN:
                begin
                    push_lim = 15;
                    pop_lim  = 75;
                end
                default:
                begin
                    push_lim = 35;
                    pop_lim  = 65;
                end
            endcase
            pick = $urandom_range(0, 99);
            if (pick < push_lim)
            begin
                f = OP_PUSH;
                v = pick_value();
            end
            else if (pick < pop_lim)
            begin
                f = OP_POP;
                v = $urandom;
            end
            else if (pick < 97)
            begin
                f = OP_SEARCH;
                v = pick_key();
            end
            else
            begin
                f = OP_NONE;
                v = $urandom;
            end
            offer_req(f, v);
            sender_gap(gaps);
        end
    endtask

    initial
    begin : stim
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stack, unused selector, extremes, hit, miss, duplicate top
        offer_req(OP_POP, 32'sh0000_0000);
        offer_req(OP_SEARCH, 32'sh0000_0000);
        offer_req(OP_NONE, 32'shFFFF_FFFF);
        offer_req(OP_PUSH, 32'sh8000_0000);
        offer_req(OP_PUSH, 32'sh7FFF_FFFF);
        offer_req(OP_PUSH, 32'sh0000_0000);
        offer_req(OP_PUSH, 32'shFFFF_FFFF);
        offer_req(OP_PUSH, 32'sh7FFF_FFFF);
        offer_req(OP_SEARCH, 32'sh7FFF_FFFF);
        offer_req(OP_SEARCH, 32'sh8000_0000);
        offer_req(OP_SEARCH, 32'sh0000_3039);
        offer_req(OP_POP, 32'shFFFF_FFFF);
        // fill up, push into a full stack, match at the bottom
        for (int k = 0; k < 12; k++)
            offer_req(OP_PUSH, $urandom);
        offer_req(OP_PUSH, 32'sh1234_5678);
        offer_req(OP_SEARCH, 32'sh8000_0000);
        wait_all_answered();

        idle_on = 1'b1;
        run_random(350, 1'b1);

        // sink holds off while requests keep coming, so the input backs up
        long_hold_req = 1'b1;
        run_random(80, 1'b0);
        wait_all_answered();

        run_random(350, 1'b1);
        wait_all_answered();
        run_random(500, 1'b1);

        idle_on = 1'b0;
        run_random(400, 1'b0);
        wait_all_answered();
        repeat (DEPTH + 8) @(posedge clk);

        if (sb.pending_rsp.size() != 0)
        begin
            $display("%0d items never answered", sb.pending_rsp.size());
            sb.mismatch_cnt++;
        end
        if (sb.mismatch_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lss_pkg.sv
src/lss_ram.sv
src/lifo_stack_with_search_top.sv
sim/lifo_stack_with_search_top_tb.sv
